[rtl/c_like_token_scanner_core_assert.svh]
// Assertion macros for the token scanner checker.
`ifndef C_LIKE_TOKEN_SCANNER_CORE_ASSERT_SVH
`define C_LIKE_TOKEN_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define CTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("token scanner check failed");

// next-cycle implication
`define CTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("token scanner check failed");

`endif

[rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg
// Types, codes and tables shared by the token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int KEYWORD_CHARS_DEF  = 7;
    localparam int NUM_KEYWORDS       = 14;

    localparam logic [5:0] K_END     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd37;
    localparam logic [5:0] K_STRING  = 6'd38;
    localparam logic [5:0] K_CHAR    = 6'd39;
    localparam logic [5:0] K_FLOAT   = 6'd40;
    localparam logic [5:0] K_DOUBLE  = 6'd41;
    localparam logic [5:0] K_INTEGER = 6'd42;

    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_OPEN_STR   = 3'd1;
    localparam logic [2:0] E_BAD_ESC    = 3'd2;
    localparam logic [2:0] E_OPEN_CHAR  = 3'd3;
    localparam logic [2:0] E_INT_OVF    = 3'd4;
    localparam logic [2:0] E_UNEXPECTED = 3'd5;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_EQ   = 3'd1;
    localparam logic [2:0] OP_NOT  = 3'd2;
    localparam logic [2:0] OP_GT   = 3'd3;
    localparam logic [2:0] OP_LT   = 3'd4;

    localparam logic [2:0] PH_INT  = 3'd0;
    localparam logic [2:0] PH_FRAC = 3'd1;
    localparam logic [2:0] PH_EXP  = 3'd2;
    localparam logic [2:0] PH_EXPD = 3'd3;

    localparam logic [15:0] LEN_MAX   = 16'hFFFF;
    localparam logic [66:0] INT_LIMIT = 67'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_STRING, M_CHAR_VAL, M_CHAR_ESC, M_CHAR_CLOSE, M_NUMBER, M_OPERATOR
    } t_mode;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] lexeme_length;
        logic [7:0]  literal_char;
        logic        literal_escaped;
        logic [2:0]  error_code;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
        64'h6669, 64'h65736c65, 64'h726f66, 64'h656c696877, 64'h6e7275746572,
        64'h746e69, 64'h74616f6c66, 64'h656c62756f64, 64'h6e61656c6f6f62,
        64'h72616863, 64'h676e69727473, 64'h65757274, 64'h65736c6166, 64'h6c6c756e
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd2, 4'd4, 4'd3, 4'd5, 4'd6, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4, 4'd6, 4'd4, 4'd5, 4'd4
    };
    localparam logic [5:0] KW_KIND [NUM_KEYWORDS] = '{
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34,
        6'd35, 6'd35, 6'd36
    };

    function automatic logic [5:0] sym_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "(": k = 6'd1;
            ")": k = 6'd2;
            "{": k = 6'd3;
            "}": k = 6'd4;
            "[": k = 6'd5;
            "]": k = 6'd6;
            ";": k = 6'd7;
            ":": k = 6'd8;
            ",": k = 6'd9;
            ".": k = 6'd10;
            "+": k = 6'd11;
            "-": k = 6'd12;
            "*": k = 6'd13;
            "/": k = 6'd14;
            "%": k = 6'd15;
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word_first(input logic [7:0] c);
        return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_escape(input logic [7:0] c);
        return c == "'" || c == "\"" || c == "?" || c == "\\" || c == "a" || c == "b" ||
               c == "f" || c == "n" || c == "r" || c == "t" || c == "v";
    endfunction

endpackage

[rtl/cts_in_if.sv]
// ----------------------------------------------------------------------------
// cts_in_if
// Character input channel.
// ----------------------------------------------------------------------------
interface cts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

[rtl/cts_out_if.sv]
// ----------------------------------------------------------------------------
// cts_out_if
// Token result channel.
// ----------------------------------------------------------------------------
interface cts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] lexeme_length;
    logic [7:0]  literal_char;
    logic        literal_escaped;
    logic [2:0]  error_code;
    logic        last_result;
    modport source (output valid, output token_kind, output start_line, output start_column,
                    output lexeme_length, output literal_char, output literal_escaped,
                    output error_code, output last_result, input ready);
    modport sink (input valid, input token_kind, input start_line, input start_column,
                  input lexeme_length, input literal_char, input literal_escaped,
                  input error_code, input last_result, output ready);
endinterface

[rtl/c_like_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// c_like_token_scanner_core
// Lexical scanner for a small C-like language, one character per word.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  i_in     in   character (8b), 0 = end of text
//  o_out    out  token kind, start line/column, length, char literal, error, last
//
//  One character is taken per cycle; its zero, one or two tokens enter a
//  four-entry result queue the same cycle and leave one per cycle while ready is high.
//  Input stalls only while fewer than two queue entries are free.
//  Synchronous active-low reset clears the queue and the scanner state.
//  After END or an error no further tokens appear until reset.
module c_like_token_scanner_core import cts_pkg::*; #(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int KEYWORD_CHARS  = KEYWORD_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cts_in_if.sink    i_in,
    cts_out_if.source o_out
);
    t_push   push;
    t_result res;
    logic    room;

    assign i_in.ready = room;

    cts_scan #(.POSITION_WIDTH(POSITION_WIDTH), .KEYWORD_CHARS(KEYWORD_CHARS)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(i_in.valid && room),
        .i_char(i_in.character), .o_push(push)
    );

    cts_rq u_rq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_room(room),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_data(res)
    );

    assign o_out.token_kind      = res.token_kind;
    assign o_out.start_line      = res.start_line;
    assign o_out.start_column    = res.start_column;
    assign o_out.lexeme_length   = res.lexeme_length;
    assign o_out.literal_char    = res.literal_char;
    assign o_out.literal_escaped = res.literal_escaped;
    assign o_out.error_code      = res.error_code;
    assign o_out.last_result     = res.last_result;

endmodule

[rtl/cts_scan.sv]
// ----------------------------------------------------------------------------
// cts_scan
// Scanner state and one-character step logic; yields up to two results.
// ----------------------------------------------------------------------------
module cts_scan import cts_pkg::*; #(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int KEYWORD_CHARS  = KEYWORD_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    output t_push      o_push
);
    localparam int PW     = POSITION_WIDTH;
    localparam int PREF_W = KEYWORD_CHARS * 8;
    localparam logic [PW-1:0] POS_MAX = '1;
    localparam logic [PW-1:0] POS_ONE = PW'(1);

    t_mode              r_mode, n_mode;
    logic [2:0]         r_phase, n_phase;
    logic [2:0]         r_pend, n_pend;
    logic [PW-1:0]      r_cl, n_cl, r_cc, n_cc, r_tl, n_tl, r_tc, n_tc;
    logic [15:0]        r_tlen, n_tlen;
    logic [PREF_W-1:0]  r_pref, n_pref;
    logic [63:0]        r_acc, n_acc;
    logic               r_ovf, n_ovf;
    logic [7:0]         r_clv, n_clv;
    logic               r_cle, n_cle;
    logic               r_halt, n_halt;

    logic [PW-1:0] adv_l, adv_c;
    logic [66:0]   prod;
    logic          used, ha, hb;
    t_result       ra, rb;

    function automatic logic [15:0] pos16(input logic [PW-1:0] p);
        logic [PW+15:0] t;
        t = {16'd0, p};
        return t[15:0];
    endfunction

    function automatic t_result mk(input logic [5:0] kind, input logic [PW-1:0] l,
                                   input logic [PW-1:0] col, input logic [15:0] len,
                                   input logic [7:0] lit, input logic esc,
                                   input logic [2:0] err);
        t_result r;
        r.token_kind      = kind;
        r.start_line      = pos16(l);
        r.start_column    = pos16(col);
        r.lexeme_length   = len;
        r.literal_char    = lit;
        r.literal_escaped = esc;
        r.error_code      = err;
        r.last_result     = 1'b0;
        return r;
    endfunction

    function automatic logic [5:0] word_kind(input logic [PREF_W-1:0] pref,
                                             input logic [15:0] len);
        logic [5:0]  k;
        logic [63:0] p64;
        k   = K_IDENT;
        p64 = 64'(pref);
        for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
            if (len == 16'(KW_LEN[i]) && int'(KW_LEN[i]) <= KEYWORD_CHARS && p64 == KW_TEXT[i]) begin
                k = KW_KIND[i];
            end
        end
        return k;
    endfunction

    function automatic logic [15:0] grow(input logic [15:0] l);
        return (l == LEN_MAX) ? l : l + 16'd1;
    endfunction

    always_comb begin
        if (i_char == 8'd10) begin
            adv_l = (r_cl != POS_MAX) ? r_cl + POS_ONE : r_cl;
            adv_c = POS_ONE;
        end else begin
            adv_l = r_cl;
            adv_c = (r_cc != POS_MAX) ? r_cc + POS_ONE : r_cc;
        end
        prod = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {59'd0, i_char - 8'd48};
    end

    always_comb begin
        n_mode = r_mode; n_phase = r_phase; n_pend = r_pend;
        n_cl = r_cl; n_cc = r_cc; n_tl = r_tl; n_tc = r_tc; n_tlen = r_tlen;
        n_pref = r_pref; n_acc = r_acc; n_ovf = r_ovf; n_clv = r_clv; n_cle = r_cle;
        n_halt = r_halt;
        used = 1'b0; ha = 1'b0; hb = 1'b0; ra = '0; rb = '0;
        if (i_fire && !r_halt) begin
            unique case (r_mode)
                M_IDENT: begin
                    if (is_word_first(i_char) || is_digit(i_char)) begin
                        if (r_tlen < 16'(KEYWORD_CHARS)) begin
                            n_pref = r_pref | (PREF_W'(i_char) << {r_tlen[3:0], 3'b000});
                        end
                        n_tlen = grow(r_tlen);
                        n_cl = adv_l; n_cc = adv_c; used = 1'b1;
                    end else begin
                        ra = mk(word_kind(r_pref, r_tlen), r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_NONE);
                        ha = 1'b1; n_mode = M_IDLE;
                    end
                end
                M_NUMBER: begin
                    if (i_char == "f" || i_char == "F") begin
                        n_cl = adv_l; n_cc = adv_c; n_tlen = grow(r_tlen);
                        ra = mk(K_FLOAT, r_tl, r_tc, grow(r_tlen), 8'd0, 1'b0, E_NONE);
                        ha = 1'b1; n_mode = M_IDLE; used = 1'b1;
                    end else if (is_digit(i_char) ||
                                 (i_char == "." && r_phase == PH_INT) ||
                                 ((i_char == "e" || i_char == "E") && r_phase <= PH_FRAC) ||
                                 ((i_char == "+" || i_char == "-") && r_phase == PH_EXP)) begin
                        if (is_digit(i_char)) begin
                            if (r_phase == PH_INT && !r_ovf) begin
                                if (prod > INT_LIMIT) n_ovf = 1'b1;
                                else n_acc = prod[63:0];
                            end
                            if (r_phase == PH_EXP) n_phase = PH_EXPD;
                        end else if (i_char == ".") begin
                            n_phase = PH_FRAC;
                        end else if (i_char == "e" || i_char == "E") begin
                            n_phase = PH_EXP;
                        end else begin
                            n_phase = PH_EXPD;
                        end
                        n_cl = adv_l; n_cc = adv_c; n_tlen = grow(r_tlen); used = 1'b1;
                    end else begin
                        n_mode = M_IDLE; ha = 1'b1;
                        if (r_phase != PH_INT) begin
                            ra = mk(K_DOUBLE, r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_NONE);
                        end else if (r_ovf) begin
                            ra = mk(K_END, r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_INT_OVF);
                            n_halt = 1'b1; used = 1'b1;
                        end else begin
                            ra = mk(K_INTEGER, r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_NONE);
                        end
                    end
                end
                M_STRING: begin
                    used = 1'b1;
                    if (i_char == "\"") begin
                        n_cl = adv_l; n_cc = adv_c;
                        ra = mk(K_STRING, r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_NONE);
                        ha = 1'b1; n_mode = M_IDLE;
                    end else if (i_char == 8'd0) begin
                        ra = mk(K_END, r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_OPEN_STR);
                        ha = 1'b1; n_halt = 1'b1; n_mode = M_IDLE;
                    end else begin
                        n_tlen = grow(r_tlen); n_cl = adv_l; n_cc = adv_c;
                    end
                end
                M_CHAR_VAL: begin
                    used = 1'b1;
                    if (i_char == 8'd0) begin
                        ra = mk(K_END, r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_OPEN_CHAR);
                        ha = 1'b1; n_halt = 1'b1; n_mode = M_IDLE;
                    end else begin
                        n_cl = adv_l; n_cc = adv_c; n_tlen = 16'd1;
                        if (i_char == "\\") begin
                            n_mode = M_CHAR_ESC;
                        end else begin
                            n_clv = i_char; n_mode = M_CHAR_CLOSE;
                        end
                    end
                end
                M_CHAR_ESC: begin
                    used = 1'b1;
                    if (is_escape(i_char)) begin
                        n_cl = adv_l; n_cc = adv_c; n_tlen = 16'd2;
                        n_clv = i_char; n_cle = 1'b1; n_mode = M_CHAR_CLOSE;
                    end else begin
                        ra = mk(K_END, r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_BAD_ESC);
                        ha = 1'b1; n_halt = 1'b1; n_mode = M_IDLE;
                    end
                end
                M_CHAR_CLOSE: begin
                    used = 1'b1; ha = 1'b1; n_mode = M_IDLE;
                    if (i_char == "'") begin
                        n_cl = adv_l; n_cc = adv_c;
                        ra = mk(K_CHAR, r_tl, r_tc, r_tlen, r_clv, r_cle, E_NONE);
                    end else begin
                        ra = mk(K_END, r_tl, r_tc, r_tlen, 8'd0, 1'b0, E_OPEN_CHAR);
                        n_halt = 1'b1;
                    end
                end
                M_OPERATOR: begin
                    n_mode = M_IDLE; n_pend = OP_NONE; ha = 1'b1;
                    if (i_char == "=") begin
                        n_cl = adv_l; n_cc = adv_c; used = 1'b1;
                        ra = mk(6'd15 + {2'b00, r_pend[1:0], 1'b0} +
                                ((r_pend == OP_LT) ? 6'd8 : 6'd0),
                                r_tl, r_tc, 16'd2, 8'd0, 1'b0, E_NONE);
                    end else begin
                        ra = mk(6'd14 + {2'b00, r_pend[1:0], 1'b0} +
                                ((r_pend == OP_LT) ? 6'd8 : 6'd0),
                                r_tl, r_tc, 16'd1, 8'd0, 1'b0, E_NONE);
                    end
                end
                default: n_mode = M_IDLE;
            endcase

            if (!used) begin
                priority if (i_char == 8'd0) begin
                    n_tl = r_cl; n_tc = r_cc;
                    rb = mk(K_END, r_cl, r_cc, 16'd0, 8'd0, 1'b0, E_NONE);
                    hb = 1'b1; n_halt = 1'b1;
                end else if (is_space(i_char)) begin
                    n_cl = adv_l; n_cc = adv_c;
                end else if (sym_kind(i_char) != K_END) begin
                    n_tl = r_cl; n_tc = r_cc; n_tlen = 16'd1; n_cl = adv_l; n_cc = adv_c;
                    rb = mk(sym_kind(i_char), r_cl, r_cc, 16'd1, 8'd0, 1'b0, E_NONE);
                    hb = 1'b1;
                end else if (i_char == "=" || i_char == "!" || i_char == ">" || i_char == "<") begin
                    n_pend = (i_char == "=") ? OP_EQ : (i_char == "!") ? OP_NOT :
                             (i_char == ">") ? OP_GT : OP_LT;
                    n_tl = r_cl; n_tc = r_cc; n_tlen = 16'd1; n_cl = adv_l; n_cc = adv_c;
                    n_mode = M_OPERATOR;
                end else if (is_word_first(i_char)) begin
                    n_tl = r_cl; n_tc = r_cc; n_tlen = 16'd1; n_cl = adv_l; n_cc = adv_c;
                    n_pref = PREF_W'(i_char); n_mode = M_IDENT;
                end else if (i_char == "\"") begin
                    n_tl = r_cl; n_tc = r_cc; n_tlen = 16'd0; n_cl = adv_l; n_cc = adv_c;
                    n_mode = M_STRING;
                end else if (i_char == "'") begin
                    n_tl = r_cl; n_tc = r_cc; n_tlen = 16'd0; n_cl = adv_l; n_cc = adv_c;
                    n_clv = 8'd0; n_cle = 1'b0; n_mode = M_CHAR_VAL;
                end else if (is_digit(i_char)) begin
                    n_tl = r_cl; n_tc = r_cc; n_tlen = 16'd1; n_cl = adv_l; n_cc = adv_c;
                    n_acc = 64'(i_char - 8'd48); n_ovf = 1'b0; n_phase = PH_INT;
                    n_mode = M_NUMBER;
                end else begin
                    n_tl = r_cl; n_tc = r_cc; n_tlen = 16'd0;
                    rb = mk(K_END, r_cl, r_cc, 16'd0, 8'd0, 1'b0, E_UNEXPECTED);
                    hb = 1'b1; n_halt = 1'b1; n_mode = M_IDLE;
                end
            end
        end

        o_push = '0;
        if (ha && hb) begin
            o_push.count = 2'd2; o_push.r0 = ra; o_push.r1 = rb;
            o_push.r1.last_result = 1'b1;
        end else if (ha || hb) begin
            o_push.count = 2'd1; o_push.r0 = ha ? ra : rb;
            o_push.r0.last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_phase <= PH_INT; r_pend <= OP_NONE;
            r_cl <= POS_ONE; r_cc <= POS_ONE; r_tl <= '0; r_tc <= '0; r_tlen <= '0;
            r_pref <= '0; r_acc <= '0; r_ovf <= 1'b0; r_clv <= '0; r_cle <= 1'b0;
            r_halt <= 1'b0;
        end else begin
            r_mode <= n_mode; r_phase <= n_phase; r_pend <= n_pend;
            r_cl <= n_cl; r_cc <= n_cc; r_tl <= n_tl; r_tc <= n_tc; r_tlen <= n_tlen;
            r_pref <= n_pref; r_acc <= n_acc; r_ovf <= n_ovf; r_clv <= n_clv; r_cle <= n_cle;
            r_halt <= n_halt;
        end
    end

endmodule

[rtl/cts_rq.sv]
// ----------------------------------------------------------------------------
// cts_rq
// Four-entry result queue; takes up to two results a cycle, gives one when i_ready is high.
// ----------------------------------------------------------------------------
module cts_rq import cts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);
    t_result    r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid = r_cnt != 3'd0;
    assign o_room  = r_cnt <= 3'd2;
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wp] <= i_push.r0;
        if (i_push.count == 2'd2) r_mem[r_wp + 2'd1] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push.count;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push.count} - {2'b00, pop};
        end
    end

endmodule

[rtl/cts_chk.sv]
// ----------------------------------------------------------------------------
// cts_chk
// Port-level checks for the token scanner.
// ----------------------------------------------------------------------------
`include "c_like_token_scanner_core_assert.svh"

module cts_chk import cts_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [5:0] i_kind,
    input logic       i_esc,
    input logic [2:0] i_err,
    input logic       i_last
);
    `CTS_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `CTS_ASSERT_IMP(a_err_end, i_clk, i_rst_n, i_valid && i_err != E_NONE, i_kind == K_END && i_last)
    `CTS_ASSERT_IMP(a_esc_char, i_clk, i_rst_n, i_valid && i_esc, i_kind == K_CHAR)
    `CTS_ASSERT_NXT(a_end_stop, i_clk, i_rst_n, i_valid && i_ready && i_kind == K_END, !i_valid)
endmodule

bind c_like_token_scanner_core cts_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(o_out.valid), .i_ready(o_out.ready),
    .i_kind(o_out.token_kind), .i_esc(o_out.literal_escaped), .i_err(o_out.error_code),
    .i_last(o_out.last_result)
);

[tb/sv/c_like_token_scanner_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_like_token_scanner_core_checker
// Watches the character and token channels of the scanner, predicts the
// tokens of every accepted character and compares each accepted token,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module c_like_token_scanner_core_checker import cts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cts_in_if    i_in,
    cts_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [15:0] POS_MAX = 16'hFFFF;

    t_result     expected_tokens[$];
    int          fail_count;
    int          step_emits;
    string       symbol_set = "(){}[];:,.+-*/%";

    t_mode       mode;
    logic [2:0]  phase;
    logic [2:0]  pend_op;
    logic [15:0] cur_line, cur_col, tok_line, tok_col, tok_len;
    logic [63:0] prefix, acc;
    logic        ovf, halted, chr_esc;
    logic [7:0]  chr_val;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void move_pos(input logic [7:0] c);
        if (c == 8'h0A) begin
            if (cur_line != POS_MAX) cur_line++;
            cur_col = 16'd1;
        end else if (cur_col != POS_MAX) begin
            cur_col++;
        end
    endfunction

    function automatic void grow();
        if (tok_len != LEN_MAX) tok_len++;
    endfunction

    function automatic void start_tok(input logic [7:0] c);
        tok_line = cur_line;
        tok_col  = cur_col;
        tok_len  = 16'd1;
        move_pos(c);
    endfunction

    function automatic void emit(input logic [5:0] kind, input logic [15:0] len,
                                 input logic [7:0] lit, input logic esc, input logic [2:0] err);
        t_result r;
        if (step_emits >= 2) return;
        r.token_kind      = kind;
        r.start_line      = tok_line;
        r.start_column    = tok_col;
        r.lexeme_length   = len;
        r.literal_char    = lit;
        r.literal_escaped = esc;
        r.error_code      = err;
        r.last_result     = 1'b0;
        expected_tokens.insert(expected_tokens.size(), r);
        step_emits++;
    endfunction

    function automatic void abort(input logic [2:0] err);
        emit(K_END, tok_len, 8'd0, 1'b0, err);
        halted = 1'b1;
        mode   = M_IDLE;
    endfunction

    function automatic logic [5:0] word_token_kind();
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (16'(KW_LEN[k]) == tok_len && KW_LEN[k] <= KEYWORD_CHARS_DEF &&
                KW_TEXT[k] == prefix) return KW_KIND[k];
        end
        return K_IDENT;
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void idle_char(input logic [7:0] c);
        if (c == 8'd0) begin
            tok_line = cur_line;
            tok_col  = cur_col;
            emit(K_END, 16'd0, 8'd0, 1'b0, E_NONE);
            halted = 1'b1;
            return;
        end
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            move_pos(c);
            return;
        end
        for (int i = 0; i < 15; i++) begin
            if (symbol_set[i] == c) begin
                start_tok(c);
                emit(6'(i + 1), 16'd1, 8'd0, 1'b0, E_NONE);
                return;
            end
        end
        if (c == "=" || c == "!" || c == ">" || c == "<") begin
            pend_op = c == "=" ? OP_EQ : c == "!" ? OP_NOT : c == ">" ? OP_GT : OP_LT;
            start_tok(c);
            mode = M_OPERATOR;
        end else if (word_start(c)) begin
            start_tok(c);
            prefix = 64'(c);
            mode   = M_IDENT;
        end else if (c == "\"") begin
            start_tok(c);
            tok_len = 16'd0;
            mode    = M_STRING;
        end else if (c == "'") begin
            start_tok(c);
            tok_len = 16'd0;
            chr_val = 8'd0;
            chr_esc = 1'b0;
            mode    = M_CHAR_VAL;
        end else if (digit(c)) begin
            start_tok(c);
            acc   = 64'(c - "0");
            ovf   = 1'b0;
            phase = PH_INT;
            mode  = M_NUMBER;
        end else begin
            tok_line = cur_line;
            tok_col  = cur_col;
            tok_len  = 16'd0;
            abort(E_UNEXPECTED);
        end
    endfunction

    function automatic logic number_char(input logic [7:0] c);
        logic        take;
        logic [63:0] d;
        take = 1'b0;
        if (c == "f" || c == "F") begin
            move_pos(c);
            grow();
            emit(K_FLOAT, tok_len, 8'd0, 1'b0, E_NONE);
            mode = M_IDLE;
            return 1'b1;
        end
        if (digit(c)) begin
            take = 1'b1;
            if (phase == PH_INT && !ovf) begin
                d = 64'(c - "0");
                if (acc > (INT_LIMIT[63:0] - d) / 64'd10) ovf = 1'b1;
                else acc = acc * 64'd10 + d;
            end
            if (phase == PH_EXP) phase = PH_EXPD;
        end else if (c == "." && phase == PH_INT) begin
            take  = 1'b1;
            phase = PH_FRAC;
        end else if ((c == "e" || c == "E") && phase <= PH_FRAC) begin
            take  = 1'b1;
            phase = PH_EXP;
        end else if ((c == "+" || c == "-") && phase == PH_EXP) begin
            take  = 1'b1;
            phase = PH_EXPD;
        end
        if (take) begin
            move_pos(c);
            grow();
            return 1'b1;
        end
        mode = M_IDLE;
        if (phase != PH_INT) begin
            emit(K_DOUBLE, tok_len, 8'd0, 1'b0, E_NONE);
        end else if (ovf) begin
            abort(E_INT_OVF);
            return 1'b1;
        end else begin
            emit(K_INTEGER, tok_len, 8'd0, 1'b0, E_NONE);
        end
        return 1'b0;
    endfunction

    function automatic void predict_tokens(input logic [7:0] c);
        logic used;
        int   last;
        if (halted) return;
        step_emits = 0;
        used = 1'b0;
        case (mode)
            M_IDENT: begin
                if (word_start(c) || digit(c)) begin
                    if (tok_len < KEYWORD_CHARS_DEF) prefix |= 64'(c) << (8 * tok_len);
                    grow();
                    move_pos(c);
                    used = 1'b1;
                end else begin
                    emit(word_token_kind(), tok_len, 8'd0, 1'b0, E_NONE);
                    mode = M_IDLE;
                end
            end
            M_NUMBER: used = number_char(c);
            M_STRING: begin
                used = 1'b1;
                if (c == "\"") begin
                    move_pos(c);
                    emit(K_STRING, tok_len, 8'd0, 1'b0, E_NONE);
                    mode = M_IDLE;
                end else if (c == 8'd0) begin
                    abort(E_OPEN_STR);
                end else begin
                    grow();
                    move_pos(c);
                end
            end
            M_CHAR_VAL: begin
                used = 1'b1;
                if (c == 8'd0) begin
                    abort(E_OPEN_CHAR);
                end else begin
                    move_pos(c);
                    tok_len = 16'd1;
                    if (c == "\\") begin
                        mode = M_CHAR_ESC;
                    end else begin
                        chr_val = c;
                        mode    = M_CHAR_CLOSE;
                    end
                end
            end
            M_CHAR_ESC: begin
                used = 1'b1;
                if (c == "'" || c == "\"" || c == "?" || c == "\\" || c == "a" || c == "b" ||
                    c == "f" || c == "n" || c == "r" || c == "t" || c == "v") begin
                    move_pos(c);
                    tok_len = 16'd2;
                    chr_val = c;
                    chr_esc = 1'b1;
                    mode    = M_CHAR_CLOSE;
                end else begin
                    abort(E_BAD_ESC);
                end
            end
            M_CHAR_CLOSE: begin
                used = 1'b1;
                if (c == "'") begin
                    move_pos(c);
                    emit(K_CHAR, tok_len, chr_val, chr_esc, E_NONE);
                    mode = M_IDLE;
                end else begin
                    abort(E_OPEN_CHAR);
                end
            end
            M_OPERATOR: begin
                mode = M_IDLE;
                if (c == "=") begin
                    move_pos(c);
                    emit(6'(15 + 2 * pend_op[1:0] + (pend_op == OP_LT ? 8 : 0)),
                         16'd2, 8'd0, 1'b0, E_NONE);
                    used = 1'b1;
                end else begin
                    emit(6'(14 + 2 * pend_op[1:0] + (pend_op == OP_LT ? 8 : 0)),
                         16'd1, 8'd0, 1'b0, E_NONE);
                end
                pend_op = OP_NONE;
            end
            default: mode = M_IDLE;
        endcase
        if (!used && !halted) idle_char(c);
        if (step_emits > 0) begin
            last = expected_tokens.size() - 1;
            expected_tokens[last].last_result = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            mode     = M_IDLE;
            phase    = PH_INT;
            pend_op  = OP_NONE;
            cur_line = 16'd1;
            cur_col  = 16'd1;
            tok_line = 16'd0;
            tok_col  = 16'd0;
            tok_len  = 16'd0;
            prefix   = 64'd0;
            acc      = 64'd0;
            ovf      = 1'b0;
            chr_val  = 8'd0;
            chr_esc  = 1'b0;
            halted   = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_in.valid && i_in.ready) predict_tokens(i_in.character);
            if (i_out.valid && i_out.ready) begin
                if (expected_tokens.size() == 0) begin
                    report("unexpected word, kind", i_out.token_kind, -1);
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_out.token_kind != want.token_kind)
                        report("token_kind", i_out.token_kind, want.token_kind);
                    if (i_out.start_line != want.start_line)
                        report("start_line", i_out.start_line, want.start_line);
                    if (i_out.start_column != want.start_column)
                        report("start_column", i_out.start_column, want.start_column);
                    if (i_out.lexeme_length != want.lexeme_length)
                        report("lexeme_length", i_out.lexeme_length, want.lexeme_length);
                    if (i_out.literal_char != want.literal_char)
                        report("literal_char", i_out.literal_char, want.literal_char);
                    if (i_out.literal_escaped != want.literal_escaped)
                        report("literal_escaped", i_out.literal_escaped, want.literal_escaped);
                    if (i_out.error_code != want.error_code)
                        report("error_code", i_out.error_code, want.error_code);
                    if (i_out.last_result != want.last_result)
                        report("last_result", i_out.last_result, want.last_result);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_tokens.size();
    end

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

[tb/sv/c_like_token_scanner_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_like_token_scanner_core_tb
// Feeds the scanner one long source text: a directed opening, then random
// well-formed tokens and whitespace with random gaps and stalls, closed by
// end of text or by one randomly chosen error. The checker does the scoring.
// ----------------------------------------------------------------------------
module c_like_token_scanner_core_tb;

    localparam int TEXT_WORDS  = 1500;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic      i_clk;
    logic      i_rst_n;
    int        fail_count;
    int        pending;
    int        cycles;
    byte       source_text[$];

    cts_in_if  chars_if ();
    cts_out_if tokens_if ();

    c_like_token_scanner_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chars_if),
        .o_out   (tokens_if)
    );

    c_like_token_scanner_core_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (chars_if),
        .i_out        (tokens_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void add_byte(input byte b);
        source_text.insert(source_text.size(), b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic byte pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void add_digits(input int n);
        for (int i = 0; i < n; i++) add_byte(pick("0123456789"));
    endfunction

    function automatic void add_token();
        string kw[] = '{"if", "else", "for", "while", "return", "int", "float", "double",
                        "boolean", "char", "string", "true", "false", "null", "booleans",
                        "nul", "iff", "returned", "Int"};
        string ops[] = '{"=", "==", "!", "!=", ">", ">=", "<", "<="};
        string word_rest = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        byte   b;
        case ($urandom_range(0, 9))
            0: begin
                add_byte(pick("abcxyzABCXYZ_"));
                repeat ($urandom_range(0, 11)) add_byte(pick(word_rest));
            end
            1: add_text(kw[$urandom_range(0, kw.size() - 1)]);
            2: begin
                add_digits($urandom_range(1, 18));
                if ($urandom_range(0, 1)) begin
                    add_byte(".");
                    add_digits($urandom_range(0, 3));
                end
                if ($urandom_range(0, 2) == 0) begin
                    add_byte(pick("eE"));
                    if ($urandom_range(0, 1)) add_byte(pick("+-"));
                    add_digits($urandom_range(0, 3));
                end
                if ($urandom_range(0, 3) == 0) add_byte(pick("fF"));
                add_byte(pick(" \n\t"));
            end
            3: begin
                add_byte("\"");
                repeat ($urandom_range(0, 8)) begin
                    do b = byte'($urandom_range(1, 255)); while (b == "\"");
                    add_byte(b);
                end
                add_byte("\"");
            end
            4: begin
                add_byte("'");
                if ($urandom_range(0, 1)) begin
                    add_byte("\\");
                    add_byte(pick("'\"?\\abfnrtv"));
                end else begin
                    do b = byte'($urandom_range(1, 255)); while (b == "\\");
                    add_byte(b);
                end
                add_byte("'");
            end
            5: add_byte(pick("(){}[];:,.+-*/%"));
            6: add_text(ops[$urandom_range(0, ops.size() - 1)]);
            default: add_byte(byte'($urandom_range(0, 5) == 0 ?
                                    $urandom_range(9, 13) : 32));
        endcase
    endfunction

    function automatic void add_ending();
        case ($urandom_range(0, 8))
            0: add_text("\"open");
            1: add_text("'\\q");
            2: add_text("'");
            3: add_text("'ab");
            4: add_text("99999999999999999999 ");
            5: add_text("#");
            6: add_text("tail");
            7: add_text("<");
            default: add_text(" ");
        endcase
        add_byte(8'd0);
        add_text(" x;");
    endfunction

    // receiver: random stalls and one long hold-off
    initial begin
        int got;
        int hold;
        tokens_if.ready = 1'b0;
        got = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (got == 150) hold = 400;
            else if ((got / 40) % 2 == 1) hold = 0;
            else hold = $urandom_range(0, 16);
            if (hold > 0) begin
                tokens_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            tokens_if.ready <= 1'b1;
            do @(posedge i_clk); while (!tokens_if.valid);
            got++;
        end
    end

    initial begin
        int  gap;
        bit  calm;
        chars_if.valid     = 1'b0;
        chars_if.character = 8'd0;
        i_rst_n            = 1'b0;
        cycles             = 0;
        calm               = 1'b0;

        add_text("==!=>=<=\"");
        add_byte(8'hFF);
        add_byte(8'h01);
        add_text("\"'\\?''");
        add_byte(8'h80);
        add_text("'1.e-5F 9E\nz_9 ");
        while (source_text.size() < TEXT_WORDS) add_token();
        add_ending();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < source_text.size(); n++) begin
            if (n % 64 == 0) calm = $urandom_range(0, 3) == 0;
            gap = calm ? 0 : $urandom_range(0, 16);
            if (n == 700) begin
                chars_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end else if (gap > 0) begin
                chars_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            chars_if.valid     <= 1'b1;
            chars_if.character <= source_text[n];
            do @(posedge i_clk); while (!chars_if.ready);
        end
        chars_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/cts_pkg.sv
rtl/cts_in_if.sv
rtl/cts_out_if.sv
rtl/cts_scan.sv
rtl/cts_rq.sv
rtl/c_like_token_scanner_core.sv
rtl/cts_chk.sv
tb/sv/c_like_token_scanner_core_checker.sv
tb/sv/c_like_token_scanner_core_tb.sv
